### rtl/tsc_pkg.sv
// tsc_pkg: shared widths, function codes and the microcode program of the
// series evaluator. No dependencies; used by the interfaces and the top level.
`default_nettype none

package tsc_pkg;

  // Field widths fixed by the item formats
  localparam int ARG_W   = 27;
  localparam int VALUE_W = 28;
  localparam int TERMS_W = 5;
  localparam int EPS_W   = 25;
  localparam int FUNC_W  = 2;

  localparam logic [EPS_W-1:0] EPS_RESET = 25'd16777;  // about 0.001

  // Divider retires this many quotient bits per cycle
  localparam int DIV_BITS = 8;

  // Function select codes
  localparam logic [FUNC_W-1:0] FUNC_EXP  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SIN  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COS  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

  // Program counter and step addresses
  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] S_IDLE  = 3'd0;
  localparam logic [PC_W-1:0] S_CHECK = 3'd1;
  localparam logic [PC_W-1:0] S_ADD   = 3'd2;
  localparam logic [PC_W-1:0] S_MUL   = 3'd3;
  localparam logic [PC_W-1:0] S_DIV   = 3'd4;
  localparam logic [PC_W-1:0] S_UPD   = 3'd5;
  localparam logic [PC_W-1:0] S_EMIT  = 3'd6;

  // Sequencing conditions
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] C_NEXT     = 3'd0;  // fall through
  localparam logic [COND_W-1:0] C_JUMP     = 3'd1;  // always jump
  localparam logic [COND_W-1:0] C_WAIT_IN  = 3'd2;  // hold until an item arrives
  localparam logic [COND_W-1:0] C_WAIT_OUT = 3'd3;  // hold until output register free
  localparam logic [COND_W-1:0] C_UNUSED   = 3'd4;  // jump on unused selector
  localparam logic [COND_W-1:0] C_STOP     = 3'd5;  // jump when summation ends
  localparam logic [COND_W-1:0] C_LOOP     = 3'd6;  // repeat until divider done

  // One control word
  typedef struct packed {
    logic              ld;    // capture input item, clear sum and count
    logic              sqr;   // x2 <= x*x
    logic              acc;   // add term, count it
    logic              mul;   // term product, load divider
    logic              div;   // one divider step
    logic              upd;   // take quotient as new term
    logic              emit;  // load output register
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } ucode_t;

  // Microcode ROM
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '0;
    case (pc)
      S_IDLE: begin
        w.ld = 1'b1;   w.cond = C_WAIT_IN;  w.target = S_CHECK;
      end
      S_CHECK: begin
        w.sqr = 1'b1;  w.cond = C_UNUSED;   w.target = S_EMIT;
      end
      S_ADD: begin
        w.acc = 1'b1;  w.cond = C_STOP;     w.target = S_EMIT;
      end
      S_MUL: begin
        w.mul = 1'b1;  w.cond = C_NEXT;     w.target = S_DIV;
      end
      S_DIV: begin
        w.div = 1'b1;  w.cond = C_LOOP;     w.target = S_DIV;
      end
      S_UPD: begin
        w.upd = 1'b1;  w.cond = C_JUMP;     w.target = S_ADD;
      end
      S_EMIT: begin
        w.emit = 1'b1; w.cond = C_WAIT_OUT; w.target = S_IDLE;
      end
      default: begin
        w.cond = C_JUMP; w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/tsc_in_if.sv
// tsc_in_if: input item channel (function select and argument).
// Depends on tsc_pkg for field widths.
`default_nettype none

interface tsc_in_if;
  logic                              valid;
  logic                              ready;
  logic [tsc_pkg::FUNC_W-1:0]        func;
  logic signed [tsc_pkg::ARG_W-1:0]  arg;

  modport source (output valid, output func, output arg, input ready);
  modport sink   (input valid, input func, input arg, output ready);
endinterface

`default_nettype wire

### rtl/tsc_out_if.sv
// tsc_out_if: result item channel (series sum and term count).
// Depends on tsc_pkg for field widths.
`default_nettype none

interface tsc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tsc_pkg::VALUE_W-1:0]  value;
  logic [tsc_pkg::TERMS_W-1:0]         terms_used;

  modport source (output valid, output value, output terms_used, input ready);
  modport sink   (input valid, input value, input terms_used, output ready);
endinterface

`default_nettype wire

### rtl/tsc_cfg_if.sv
// tsc_cfg_if: configuration write channel for the epsilon register.
// Depends on tsc_pkg for the register width.
`default_nettype none

interface tsc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tsc_pkg::EPS_W-1:0]   epsilon;

  modport source (output valid, output epsilon, input ready);
  modport sink   (input valid, input epsilon, output ready);
endinterface

`default_nettype wire

### rtl/taylor_series_exp_sin_cos_top.sv
// Series evaluator for exp, sine and cosine: top level with microcoded control.
// Depends on tsc_pkg and the interfaces tsc_in_if, tsc_out_if, tsc_cfg_if.
//
// Usage:
//   in_ch  : one item = func (0 exp, 1 sine, 2 cosine) and signed arg x.
//   out_ch : one result per item = saturated series sum and terms used.
//   cfg_ch : writes epsilon, the stop threshold on term magnitude; ready
//            whenever out of reset, write only while no item is in flight.
// Timing:
//   One item at a time. in_ch.ready is high only while the sequencer waits
//   for an item. Each term after the first passes through the shared
//   multiplier, DIV_STEPS divider steps (DIV_BITS quotient bits per cycle,
//   DIV_STEPS = 4 at FRAC_BITS = 24), the quotient update and the accumulate.
//   The next item is taken only after the result is loaded into the output
//   register and the sequencer is back in idle. An unused selector skips the
//   series and goes straight to the output step with a zero sum.
// Reset and stalls:
//   Reset returns the sequencer to idle, empties the output register, sets
//   epsilon to about 0.001 and holds in_ch and cfg_ch not ready. The result
//   sits in an output register; the block finishes the next item while it
//   waits and holds only at the final step if the receiver has still not
//   taken the previous result.
`default_nettype none

module taylor_series_exp_sin_cos_top #(
  parameter int MAX_TERMS = 16,
  parameter int FRAC_BITS = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  tsc_in_if.sink     in_ch,
  tsc_out_if.source  out_ch,
  tsc_cfg_if.sink    cfg_ch
);

  localparam int ARG_W     = tsc_pkg::ARG_W;
  localparam int VALUE_W   = tsc_pkg::VALUE_W;
  localparam int EPS_W     = tsc_pkg::EPS_W;
  localparam int PC_W      = tsc_pkg::PC_W;
  localparam int TW        = FRAC_BITS + 8;                  // term magnitude width
  localparam int OPW       = (TW > ARG_W) ? TW : ARG_W;      // multiplier operand width
  localparam int PW        = 2 * OPW;
  localparam int NW        = $clog2(MAX_TERMS + 1);          // term counter
  localparam int FW        = NW + 1;                         // 2n factors
  localparam int DMAX      = (2 * MAX_TERMS - 2) * (2 * MAX_TERMS - 1);
  localparam int DW        = $clog2(DMAX + 1);               // divisor width
  localparam int DIV_BITS  = tsc_pkg::DIV_BITS;
  localparam int DIV_STEPS = (TW + DIV_BITS - 1) / DIV_BITS;
  localparam int QW        = DIV_STEPS * DIV_BITS;
  localparam int DCW       = $clog2(DIV_STEPS + 1);
  localparam int SW        = TW + NW + 1;                    // exact sum width
  localparam int CW        = (TW > EPS_W) ? TW : EPS_W;

  localparam logic [TW-1:0] TERM_CAP = {TW{1'b1}};
  localparam logic [TW-1:0] TERM_ONE = TW'(1) << FRAC_BITS;

  // Sequencer
  logic [PC_W-1:0]     pc_r, pc_nxt;
  tsc_pkg::ucode_t     uc;
  logic                out_free;
  logic                stall;
  logic                stop;
  logic                div_last;

  // Datapath registers
  logic [1:0]            func_r;
  logic                  xneg_r;
  logic [ARG_W-1:0]      xmag_r;
  logic [TW-1:0]         x2_r;
  logic [TW-1:0]         mag_r;
  logic                  neg_r;
  logic [NW-1:0]         n_r;
  logic signed [SW-1:0]  sum_r;
  logic [DW-1:0]         d_r;
  logic [QW-1:0]         quo_r;
  logic [DW-1:0]         rem_r;
  logic [DCW-1:0]        dcnt_r;
  logic [EPS_W-1:0]      eps_r;
  logic                  out_valid_r;
  logic signed [VALUE_W-1:0]      out_value_r;
  logic [tsc_pkg::TERMS_W-1:0]    out_terms_r;

  // Input decode
  logic [ARG_W-1:0]  arg_u;
  logic              xneg_in;
  logic [ARG_W-1:0]  xmag_in;
  logic [TW-1:0]     sin_init;

  assign arg_u    = in_ch.arg;
  assign xneg_in  = arg_u[ARG_W-1];
  assign xmag_in  = xneg_in ? (~arg_u + ARG_W'(1)) : arg_u;
  assign sin_init = (OPW'(xmag_in) > OPW'(TERM_CAP)) ? TERM_CAP : TW'(xmag_in);

  assign uc = tsc_pkg::ucode_rom(pc_r);

  // Shared multiplier: x*x or term*x / term*x2, truncated and capped
  logic [OPW-1:0] mul_a, mul_b;
  logic [PW-1:0]  prod, prod_sh;
  logic [TW-1:0]  mul_res;

  assign mul_a   = uc.sqr ? OPW'(xmag_r) : OPW'(mag_r);
  assign mul_b   = (uc.sqr || func_r == tsc_pkg::FUNC_EXP) ? OPW'(xmag_r) : OPW'(x2_r);
  assign prod    = PW'(mul_a) * PW'(mul_b);
  assign prod_sh = prod >> FRAC_BITS;
  assign mul_res = (prod_sh > PW'(TERM_CAP)) ? TERM_CAP : TW'(prod_sh);

  // Factorial factors for the next term
  logic [FW-1:0]    n2, fa, fb;
  logic [2*FW-1:0]  dprod;
  logic [DW-1:0]    d_next;

  assign n2     = FW'(n_r) << 1;
  assign fa     = (func_r == tsc_pkg::FUNC_SIN) ? n2 : (n2 - FW'(1));
  assign fb     = (func_r == tsc_pkg::FUNC_SIN) ? (n2 + FW'(1)) : n2;
  assign dprod  = (2*FW)'(fa) * (2*FW)'(fb);
  assign d_next = (func_r == tsc_pkg::FUNC_EXP) ? DW'(n_r) : DW'(dprod);

  // Restoring divider, DIV_BITS quotient bits per cycle
  logic [DW-1:0]  rem_c;
  logic [QW-1:0]  quo_c;
  logic [DW:0]    trial;

  always_comb begin
    rem_c = rem_r;
    quo_c = quo_r;
    trial = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial = {rem_c, quo_c[QW-1]};
      if (trial >= {1'b0, d_r}) begin
        rem_c = DW'(trial - {1'b0, d_r});
        quo_c = {quo_c[QW-2:0], 1'b1};
      end else begin
        rem_c = DW'(trial);
        quo_c = {quo_c[QW-2:0], 1'b0};
      end
    end
  end

  assign div_last = (dcnt_r == DCW'(DIV_STEPS - 1));

  // Term accumulate and stop test
  logic [NW-1:0]        n_inc;
  logic [SW-1:0]        mag_ext;
  logic signed [SW-1:0] term_s;

  assign n_inc   = n_r + NW'(1);
  assign mag_ext = SW'(mag_r);
  assign term_s  = neg_r ? -$signed(mag_ext) : $signed(mag_ext);
  assign stop    = (CW'(mag_r) < CW'(eps_r)) || (n_inc >= NW'(MAX_TERMS));

  // Final saturation to the value field
  logic                      sum_ovf;
  logic signed [VALUE_W-1:0] sum_sat;

  assign sum_ovf = !((&sum_r[SW-1:VALUE_W-1]) || !(|sum_r[SW-1:VALUE_W-1]));
  assign sum_sat = sum_ovf ? (sum_r[SW-1] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                          : {1'b0, {(VALUE_W-1){1'b1}}})
                           : sum_r[VALUE_W-1:0];

  // Next step selection
  assign out_free = !out_valid_r || out_ch.ready;
  assign stall    = ((uc.cond == tsc_pkg::C_WAIT_IN) && !in_ch.valid) ||
                    ((uc.cond == tsc_pkg::C_WAIT_OUT) && !out_free);

  always_comb begin
    case (uc.cond)
      tsc_pkg::C_NEXT:     pc_nxt = pc_r + PC_W'(1);
      tsc_pkg::C_JUMP:     pc_nxt = uc.target;
      tsc_pkg::C_WAIT_IN:  pc_nxt = in_ch.valid ? uc.target : pc_r;
      tsc_pkg::C_WAIT_OUT: pc_nxt = out_free ? uc.target : pc_r;
      tsc_pkg::C_UNUSED:   pc_nxt = (func_r == tsc_pkg::FUNC_NONE) ? uc.target
                                                                   : pc_r + PC_W'(1);
      tsc_pkg::C_STOP:     pc_nxt = stop ? uc.target : pc_r + PC_W'(1);
      tsc_pkg::C_LOOP:     pc_nxt = div_last ? pc_r + PC_W'(1) : uc.target;
      default:             pc_nxt = tsc_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= tsc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      eps_r       <= tsc_pkg::EPS_RESET;
    end else begin
      pc_r <= pc_nxt;
      if (uc.emit && !stall) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        eps_r <= cfg_ch.epsilon;
      end
    end
  end

  // Datapath registers, driven by the control word
  always_ff @(posedge clk) begin
    if (uc.ld && !stall) begin
      func_r <= in_ch.func;
      xneg_r <= xneg_in;
      xmag_r <= xmag_in;
      mag_r  <= (in_ch.func == tsc_pkg::FUNC_SIN) ? sin_init : TERM_ONE;
      neg_r  <= (in_ch.func == tsc_pkg::FUNC_SIN) ? xneg_in : 1'b0;
      n_r    <= '0;
      sum_r  <= '0;
    end
    if (uc.sqr) begin
      x2_r <= mul_res;
    end
    if (uc.acc) begin
      sum_r <= sum_r + term_s;
      n_r   <= n_inc;
    end
    if (uc.mul) begin
      quo_r  <= QW'(mul_res);
      rem_r  <= '0;
      dcnt_r <= '0;
      d_r    <= d_next;
    end
    if (uc.div) begin
      quo_r  <= quo_c;
      rem_r  <= rem_c;
      dcnt_r <= dcnt_r + DCW'(1);
    end
    if (uc.upd) begin
      mag_r <= quo_r[TW-1:0];
      neg_r <= (func_r == tsc_pkg::FUNC_EXP) ? (neg_r ^ xneg_r) : !neg_r;
    end
    if (uc.emit && !stall) begin
      out_value_r <= sum_sat;
      out_terms_r <= tsc_pkg::TERMS_W'(n_r);
    end
  end

  // Ports; nothing is taken while reset is held
  assign in_ch.ready       = rst_n && (pc_r == tsc_pkg::S_IDLE);
  assign cfg_ch.ready      = rst_n;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.value      = out_value_r;
  assign out_ch.terms_used = out_terms_r;

endmodule

`default_nettype wire
